>>> rtl/sacfp_pkg.sv
// ----------------------------------------------------------------------------
// sacfp_pkg: shared types and lookup functions
// Row layout, word structs, register codes and the per-set tag compare.
// ----------------------------------------------------------------------------
package sacfp_pkg;

    localparam int unsigned NUM_SETS  = 256;
    localparam int unsigned NUM_WAYS  = 8;
    localparam int unsigned ADDR_W    = 48;
    localparam int unsigned SET_W     = 8;
    localparam int unsigned PTR_W     = 3;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned MAX_OFF   = 16;
    localparam int unsigned MAX_IDX   = 8;
    localparam int unsigned MAX_PF    = 7;

    localparam logic [1:0] REG_OFFSET   = 2'd0;
    localparam logic [1:0] REG_INDEX    = 2'd1;
    localparam logic [1:0] REG_WAYS     = 2'd2;
    localparam logic [1:0] REG_PREFETCH = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } t_in_word;

    typedef struct packed {
        logic             plain_hit;
        logic             prefetch_hit;
        logic [2:0]       prefetch_fills_now;
        logic [CNT_W-1:0] total_reads_plain;
        logic [CNT_W-1:0] total_reads_prefetch;
        logic [CNT_W-1:0] total_writes;
        logic [CNT_W-1:0] total_hits_plain;
        logic [CNT_W-1:0] total_misses_plain;
        logic [CNT_W-1:0] total_hits_prefetch;
        logic [CNT_W-1:0] total_misses_prefetch;
    } t_out_word;

    typedef struct packed {
        logic [NUM_WAYS-1:0][ADDR_W-1:0] tag;
        logic [NUM_WAYS-1:0]             valid;
        logic [PTR_W-1:0]                fifo;
    } t_row;

    typedef struct packed {
        logic hit;
        t_row row;
    } t_lookup;

    function automatic logic [4:0] clamp_off(input logic [4:0] v);
        return (v > 5'(MAX_OFF)) ? 5'(MAX_OFF) : v;
    endfunction

    function automatic logic [3:0] clamp_idx(input logic [3:0] v);
        return (v > 4'(MAX_IDX)) ? 4'(MAX_IDX) : v;
    endfunction

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] addr,
                                                input logic [4:0] ob,
                                                input logic [3:0] ib);
        logic [ADDR_W-1:0] sh;
        logic [SET_W:0]    m;
        sh = addr >> ob;
        m  = (9'd1 << ib) - 9'd1;
        return sh[SET_W-1:0] & m[SET_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] tag_of(input logic [ADDR_W-1:0] addr,
                                                 input logic [4:0] ob,
                                                 input logic [3:0] ib);
        logic [4:0] s;
        s = ob + 5'(ib);
        return addr >> s;
    endfunction

    function automatic t_lookup lookup(input t_row r, input logic [ADDR_W-1:0] tag,
                                       input logic [3:0] ways_cfg);
        t_lookup          res;
        logic [3:0]       w;
        logic             found;
        logic             empty;
        logic [PTR_W-1:0] e;
        logic [PTR_W-1:0] p;
        w     = (ways_cfg == 4'd0) ? 4'd1 : ((ways_cfg > 4'(NUM_WAYS)) ? 4'(NUM_WAYS) : ways_cfg);
        res.row = r;
        found = 1'b0;
        empty = 1'b0;
        e     = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (i < w && r.valid[i] && r.tag[i] == tag) begin
                found = 1'b1;
            end
            if (i < w && !r.valid[i] && !empty) begin
                empty = 1'b1;
                e     = PTR_W'(i);
            end
        end
        res.hit = found;
        if (!found) begin
            if (empty) begin
                res.row.valid[e] = 1'b1;
                res.row.tag[e]   = tag;
            end else begin
                p = ({1'b0, r.fifo} >= w) ? '0 : r.fifo;
                res.row.valid[p] = 1'b1;
                res.row.tag[p]   = tag;
                res.row.fifo     = ({1'b0, p} + 4'd1 == w) ? '0 : p + 3'd1;
            end
        end
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [3:0] d);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W+1)'(d);
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/sacfp_store.sv
// ----------------------------------------------------------------------------
// sacfp_store: tag store memory
// One row per set holding all ways, valid bits and the FIFO pointer.
// ----------------------------------------------------------------------------
module sacfp_store (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [sacfp_pkg::SET_W-1:0]   i_rd_addr,
    output sacfp_pkg::t_row               o_rd_row,
    input  logic                          i_wr_en,
    input  logic [sacfp_pkg::SET_W-1:0]   i_wr_addr,
    input  sacfp_pkg::t_row               i_wr_row
);

    sacfp_pkg::t_row r_mem [sacfp_pkg::NUM_SETS];
    sacfp_pkg::t_row r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

>>> rtl/set_assoc_cache_fifo_prefetch_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_prefetch_unit: dual tag store with next-line prefetch
// Plain and prefetching set-associative caches with FIFO replacement.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one access word (address,
// is_write). Output channel: o_out_valid / i_out_stall carry one result word
// with hit flags, the prefetch fill count and the running totals.
// Configuration: APB registers offset_bits, index_bits, ways, prefetch_count
// at byte addresses 0, 4, 8, 12.
// Each access reads and writes back one row in each tag store, then loads
// the result register; after a miss in the prefetching store it first makes
// prefetch_count prefetch lookups, each a read-modify-write of one row.
// One access is in flight at a time; the next one is accepted once the
// result has loaded and the block is back in idle.
// After reset the block clears both tag stores, one set per cycle, through
// all 256 sets with o_in_stall high; counters reset to zero.
// A stalled result stays in the output register; the next access may be
// accepted meanwhile but cannot complete until the word is taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_prefetch_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sacfp_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sacfp_pkg::t_out_word  o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOK   = 3'd2;
    localparam logic [2:0] ST_PISSUE = 3'd3;
    localparam logic [2:0] ST_PLOOK  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [sacfp_pkg::SET_W-1:0] r_clr, n_clr;
    logic [4:0] r_off;
    logic [3:0] r_idx;
    logic [3:0] r_ways;
    logic [2:0] r_pf;

    logic [sacfp_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [sacfp_pkg::ADDR_W-1:0] r_pa, n_pa;
    logic r_wr, n_wr, r_ph, n_ph, r_fh, n_fh;
    logic [2:0] r_fills, n_fills, r_left, n_left;
    logic [sacfp_pkg::CNT_W-1:0] r_cnt [7];
    logic [sacfp_pkg::CNT_W-1:0] n_cnt [7];
    logic r_ovalid, n_ovalid;
    sacfp_pkg::t_out_word r_out, n_out;

    logic [4:0] ob;
    logic [3:0] ib;
    logic [2:0] npf;
    logic [sacfp_pkg::ADDR_W-1:0] step;
    logic in_acc, out_free;

    logic pl_rd, pf_rd, pl_wr, pf_wr;
    logic [sacfp_pkg::SET_W-1:0] pl_ra, pf_ra, pl_wa, pf_wa;
    sacfp_pkg::t_row pl_row, pf_row, pl_wrow, pf_wrow;
    sacfp_pkg::t_lookup pl_lk, pf_lk, pp_lk;

    assign ob   = sacfp_pkg::clamp_off(r_off);
    assign ib   = sacfp_pkg::clamp_idx(r_idx);
    assign npf  = r_pf;
    assign step = sacfp_pkg::ADDR_W'(1) << ob;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;

    assign pl_lk = sacfp_pkg::lookup(pl_row, sacfp_pkg::tag_of(r_addr, ob, ib), r_ways);
    assign pf_lk = sacfp_pkg::lookup(pf_row, sacfp_pkg::tag_of(r_addr, ob, ib), r_ways);
    assign pp_lk = sacfp_pkg::lookup(pf_row, sacfp_pkg::tag_of(r_pa, ob, ib), r_ways);

    sacfp_store u_plain (
        .i_clk     (i_clk),
        .i_rd_en   (pl_rd),
        .i_rd_addr (pl_ra),
        .o_rd_row  (pl_row),
        .i_wr_en   (pl_wr),
        .i_wr_addr (pl_wa),
        .i_wr_row  (pl_wrow)
    );

    sacfp_store u_pref (
        .i_clk     (i_clk),
        .i_rd_en   (pf_rd),
        .i_rd_addr (pf_ra),
        .o_rd_row  (pf_row),
        .i_wr_en   (pf_wr),
        .i_wr_addr (pf_wa),
        .i_wr_row  (pf_wrow)
    );

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_addr   = r_addr;
        n_pa     = r_pa;
        n_wr     = r_wr;
        n_ph     = r_ph;
        n_fh     = r_fh;
        n_fills  = r_fills;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        pl_rd    = 1'b0;
        pf_rd    = 1'b0;
        pl_wr    = 1'b0;
        pf_wr    = 1'b0;
        pl_ra    = sacfp_pkg::set_of(i_in_word.address, ob, ib);
        pf_ra    = pl_ra;
        pl_wa    = sacfp_pkg::set_of(r_addr, ob, ib);
        pf_wa    = pl_wa;
        pl_wrow  = pl_lk.row;
        pf_wrow  = pf_lk.row;
        unique case (r_state)
            ST_CLEAR: begin
                pl_wr   = 1'b1;
                pf_wr   = 1'b1;
                pl_wa   = r_clr;
                pf_wa   = r_clr;
                pl_wrow = '0;
                pf_wrow = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    pl_rd   = 1'b1;
                    pf_rd   = 1'b1;
                    n_addr  = i_in_word.address;
                    n_wr    = i_in_word.is_write;
                    n_fills = '0;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                pl_wr  = 1'b1;
                pf_wr  = 1'b1;
                n_ph   = pl_lk.hit;
                n_fh   = pf_lk.hit;
                n_pa   = r_addr + step;
                n_left = npf;
                if (pf_lk.hit || npf == 3'd0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PISSUE;
                end
            end
            ST_PISSUE: begin
                pf_rd   = 1'b1;
                pf_ra   = sacfp_pkg::set_of(r_pa, ob, ib);
                n_state = ST_PLOOK;
            end
            ST_PLOOK: begin
                pf_wr   = 1'b1;
                pf_wa   = sacfp_pkg::set_of(r_pa, ob, ib);
                pf_wrow = pp_lk.row;
                if (!pp_lk.hit) begin
                    n_fills = r_fills + 3'd1;
                end
                n_left = r_left - 3'd1;
                n_pa   = r_pa + step;
                n_state = (r_left == 3'd1) ? ST_DONE : ST_PISSUE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_cnt[0] = sacfp_pkg::sat_add(r_cnt[0], {3'd0, !r_ph});
                    n_cnt[1] = sacfp_pkg::sat_add(r_cnt[1], {3'd0, !r_fh} + {1'b0, r_fills});
                    n_cnt[2] = sacfp_pkg::sat_add(r_cnt[2], {3'd0, r_wr});
                    n_cnt[3] = sacfp_pkg::sat_add(r_cnt[3], {3'd0, r_ph});
                    n_cnt[4] = sacfp_pkg::sat_add(r_cnt[4], {3'd0, !r_ph});
                    n_cnt[5] = sacfp_pkg::sat_add(r_cnt[5], {3'd0, r_fh});
                    n_cnt[6] = sacfp_pkg::sat_add(r_cnt[6], {3'd0, !r_fh});
                    n_out.plain_hit             = r_ph;
                    n_out.prefetch_hit          = r_fh;
                    n_out.prefetch_fills_now    = r_fills;
                    n_out.total_reads_plain     = n_cnt[0];
                    n_out.total_reads_prefetch  = n_cnt[1];
                    n_out.total_writes          = n_cnt[2];
                    n_out.total_hits_plain      = n_cnt[3];
                    n_out.total_misses_plain    = n_cnt[4];
                    n_out.total_hits_prefetch   = n_cnt[5];
                    n_out.total_misses_prefetch = n_cnt[6];
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 7; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
        end
        r_addr  <= n_addr;
        r_pa    <= n_pa;
        r_wr    <= n_wr;
        r_ph    <= n_ph;
        r_fh    <= n_fh;
        r_fills <= n_fills;
        r_left  <= n_left;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= 5'd4;
            r_idx  <= 4'd4;
            r_ways <= 4'd2;
            r_pf   <= 3'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                sacfp_pkg::REG_OFFSET:   r_off  <= pwdata[4:0];
                sacfp_pkg::REG_INDEX:    r_idx  <= pwdata[3:0];
                sacfp_pkg::REG_WAYS:     r_ways <= pwdata[3:0];
                sacfp_pkg::REG_PREFETCH: r_pf   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sacfp_pkg::REG_OFFSET:   prdata = {27'd0, r_off};
            sacfp_pkg::REG_INDEX:    prdata = {28'd0, r_idx};
            sacfp_pkg::REG_WAYS:     prdata = {28'd0, r_ways};
            sacfp_pkg::REG_PREFETCH: prdata = {29'd0, r_pf};
            default:                 prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_clear_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_out_valid) else $error("result during clear");
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_LOOK)) else $error("accept did not start lookup");
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_word.prefetch_hit || o_out_word.prefetch_fills_now == 3'd0))
        else $error("fills on prefetch hit");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: set-associative cache pair with next-line prefetch
// Random and directed access words pass through the block under several
// cache settings; every result word is checked against a local tag store
// model, which covers hit flags, fill counts and all running totals.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS = sacfp_pkg::NUM_SETS * sacfp_pkg::NUM_WAYS;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    sacfp_pkg::t_in_word    in_word = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    sacfp_pkg::t_out_word   out_word;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [3:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    set_assoc_cache_fifo_prefetch_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cache model state
    logic [sacfp_pkg::ADDR_W-1:0] m_tag [2][SLOTS];
    bit                           m_vld [2][SLOTS];
    int unsigned                  m_fifo[2][sacfp_pkg::NUM_SETS];
    logic [sacfp_pkg::CNT_W-1:0]  m_cnt [7];
    int unsigned                  cfg_off = 4, cfg_idx = 4, cfg_ways = 2, cfg_pf = 1;

    sacfp_pkg::t_in_word  pending_words[$];
    sacfp_pkg::t_out_word expected_words[$];
    int        errors = 0;
    bit        sender_hold = 1'b0;
    bit        hold_start = 1'b0;
    int        hold_cycles = 0;
    logic      receiver_hold;
    bit        calm = 1'b0;

    assign receiver_hold = (hold_cycles != 0);

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic bit probe_store(input int s,
                                       input logic [sacfp_pkg::ADDR_W-1:0] addr);
        int unsigned ob, ib, w, set, base, p;
        logic [sacfp_pkg::ADDR_W-1:0] tg;
        ob = cfg_off > sacfp_pkg::MAX_OFF ? sacfp_pkg::MAX_OFF : cfg_off;
        ib = cfg_idx > sacfp_pkg::MAX_IDX ? sacfp_pkg::MAX_IDX : cfg_idx;
        w = cfg_ways == 0 ? 1 : (cfg_ways > sacfp_pkg::NUM_WAYS ? sacfp_pkg::NUM_WAYS : cfg_ways);
        set = 32'((addr >> ob) & ((1 << ib) - 1));
        tg = addr >> (ob + ib);
        base = set * sacfp_pkg::NUM_WAYS;
        for (int i = 0; i < w; i++)
            if (m_vld[s][base+i] && m_tag[s][base+i] == tg) return 1'b1;
        for (int i = 0; i < w; i++)
            if (!m_vld[s][base+i]) begin
                m_vld[s][base+i] = 1'b1;
                m_tag[s][base+i] = tg;
                return 1'b0;
            end
        p = m_fifo[s][set];
        if (p >= w) p = 0;
        m_tag[s][base+p] = tg;
        m_vld[s][base+p] = 1'b1;
        m_fifo[s][set] = (p + 1) % w;
        return 1'b0;
    endfunction

    function automatic void bump(input int k);
        if (m_cnt[k] != '1) m_cnt[k]++;
    endfunction

    function automatic sacfp_pkg::t_out_word predict_access(input sacfp_pkg::t_in_word w);
        sacfp_pkg::t_out_word r;
        logic [sacfp_pkg::ADDR_W-1:0] a;
        int unsigned fills, ob;
        fills = 0;
        if (w.is_write) bump(2);
        r.plain_hit = probe_store(0, w.address);
        if (r.plain_hit) bump(3);
        else begin bump(4); bump(0); end
        r.prefetch_hit = probe_store(1, w.address);
        if (r.prefetch_hit) bump(5);
        else begin
            bump(6);
            bump(1);
            ob = cfg_off > sacfp_pkg::MAX_OFF ? sacfp_pkg::MAX_OFF : cfg_off;
            a = w.address;
            for (int i = 0; i < cfg_pf; i++) begin
                a = a + (sacfp_pkg::ADDR_W'(1) << ob);
                if (!probe_store(1, a)) begin
                    bump(1);
                    fills++;
                end
            end
        end
        r.prefetch_fills_now = 3'(fills);
        r.total_reads_plain = m_cnt[0];
        r.total_reads_prefetch = m_cnt[1];
        r.total_writes = m_cnt[2];
        r.total_hits_plain = m_cnt[3];
        r.total_misses_plain = m_cnt[4];
        r.total_hits_prefetch = m_cnt[5];
        r.total_misses_prefetch = m_cnt[6];
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                void'(pending_words.pop_front());
                expected_words.push_back(predict_access(in_word));
            end
            if (!(in_valid && in_stall)) begin
                if (pending_words.size() > 0 &&
                    !sender_hold && (calm || $urandom_range(99) >= 17)) begin
                    in_valid <= 1'b1;
                    in_word <= pending_words[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold counter
    always @(posedge clk) begin
        if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
        else if (hold_start) hold_cycles <= 300;
    end

    // monitor
    always @(posedge clk) begin
        sacfp_pkg::t_out_word e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) report("result word with none expected");
                else begin
                    e = expected_words.pop_front();
                    if (out_word.plain_hit !== e.plain_hit) report("plain_hit");
                    if (out_word.prefetch_hit !== e.prefetch_hit) report("prefetch_hit");
                    if (out_word.prefetch_fills_now !== e.prefetch_fills_now)
                        report("prefetch_fills_now");
                    if (out_word.total_reads_plain !== e.total_reads_plain)
                        report("total_reads_plain");
                    if (out_word.total_reads_prefetch !== e.total_reads_prefetch)
                        report("total_reads_prefetch");
                    if (out_word.total_writes !== e.total_writes) report("total_writes");
                    if (out_word.total_hits_plain !== e.total_hits_plain)
                        report("total_hits_plain");
                    if (out_word.total_misses_plain !== e.total_misses_plain)
                        report("total_misses_plain");
                    if (out_word.total_hits_prefetch !== e.total_hits_prefetch)
                        report("total_hits_prefetch");
                    if (out_word.total_misses_prefetch !== e.total_misses_prefetch)
                        report("total_misses_prefetch");
                end
            end
            out_stall <= receiver_hold || (!calm && $urandom_range(99) < 17);
        end
    end

    task automatic write_reg(input logic [1:0] code, input int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {code, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (code)
            sacfp_pkg::REG_OFFSET:   cfg_off = value & 31;
            sacfp_pkg::REG_INDEX:    cfg_idx = value & 15;
            sacfp_pkg::REG_WAYS:     cfg_ways = value & 15;
            sacfp_pkg::REG_PREFETCH: cfg_pf = value & 7;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [sacfp_pkg::ADDR_W-1:0] local_addr(
        input logic [sacfp_pkg::ADDR_W-1:0] region);
        return region + sacfp_pkg::ADDR_W'($urandom_range(0, 4095));
    endfunction

    task automatic add_word(input logic [sacfp_pkg::ADDR_W-1:0] a, input bit wr);
        sacfp_pkg::t_in_word w;
        w.address = a;
        w.is_write = wr;
        pending_words.push_back(w);
    endtask

    task automatic random_phase(input int n);
        logic [sacfp_pkg::ADDR_W-1:0] region, a;
        region = sacfp_pkg::ADDR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       a = sacfp_pkg::ADDR_W'({$urandom, $urandom});
                1:       a = {1'($urandom_range(1)), 47'h0} |
                             sacfp_pkg::ADDR_W'($urandom & 32'hFFF0);
                default: a = local_addr(region);
            endcase
            if ($urandom_range(30) == 0)
                region = sacfp_pkg::ADDR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000;
            add_word(a, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < SLOTS; i++) begin
                m_vld[s][i] = 1'b0;
                m_tag[s][i] = '0;
            end
            for (int i = 0; i < sacfp_pkg::NUM_SETS; i++) m_fifo[s][i] = 0;
        end
        for (int i = 0; i < 7; i++) m_cnt[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, wrap of prefetch past the top address
        add_word('0, 1'b0);
        add_word('1, 1'b1);
        add_word('1, 1'b0);
        add_word(48'h0000_0000_0010, 1'b1);
        add_word(48'h8000_0000_0000, 1'b0);
        add_word(48'h5555_5555_5555, 1'b1);
        add_word(48'hAAAA_AAAA_AAAA, 1'b0);
        for (int i = 0; i < 6; i++) add_word(48'h100 * i, i[0]);
        drain();

        // full sets, fifo replacement, stale pointer after lowering ways
        write_reg(sacfp_pkg::REG_WAYS, 8);
        write_reg(sacfp_pkg::REG_PREFETCH, 7);
        write_reg(sacfp_pkg::REG_OFFSET, 16);
        write_reg(sacfp_pkg::REG_INDEX, 8);
        for (int i = 0; i < 10; i++) add_word(48'h0100_0000 * i, 1'b0);
        drain();
        write_reg(sacfp_pkg::REG_WAYS, 3);
        write_reg(sacfp_pkg::REG_OFFSET, 31);
        write_reg(sacfp_pkg::REG_INDEX, 15);
        write_reg(sacfp_pkg::REG_PREFETCH, 0);
        add_word(48'h0500_0000, 1'b1);
        add_word('1, 1'b0);
        add_word(48'h7_0000_0000, 1'b1);
        drain();

        // zero ways, oversize ways, zero offset and index
        write_reg(sacfp_pkg::REG_WAYS, 0);
        write_reg(sacfp_pkg::REG_OFFSET, 0);
        write_reg(sacfp_pkg::REG_INDEX, 0);
        write_reg(sacfp_pkg::REG_PREFETCH, 7);
        random_phase(150);
        drain();
        write_reg(sacfp_pkg::REG_WAYS, 15);
        write_reg(sacfp_pkg::REG_INDEX, 2);
        write_reg(sacfp_pkg::REG_OFFSET, 6);
        random_phase(300);
        drain();

        // long receiver hold so the block backs up
        hold_start = 1'b1;
        random_phase(40);
        while (hold_cycles == 0) @(posedge clk);
        hold_start = 1'b0;
        while (hold_cycles != 0) @(posedge clk);

        // sender pause until all results are back
        sender_hold = 1'b1;
        while (expected_words.size() != 0 || in_valid) @(posedge clk);
        sender_hold = 1'b0;
        drain();

        // calm stretch
        calm = 1'b1;
        random_phase(20);
        drain();
        calm = 1'b0;

        write_reg(sacfp_pkg::REG_WAYS, 1);
        write_reg(sacfp_pkg::REG_PREFETCH, 3);
        write_reg(sacfp_pkg::REG_OFFSET, 4);
        write_reg(sacfp_pkg::REG_INDEX, 4);
        random_phase(400);
        drain();
        write_reg(sacfp_pkg::REG_WAYS, 4);
        write_reg(sacfp_pkg::REG_PREFETCH, 2);
        write_reg(sacfp_pkg::REG_OFFSET, 12);
        write_reg(sacfp_pkg::REG_INDEX, 8);
        random_phase(400);
        drain();
        write_reg(sacfp_pkg::REG_WAYS, 2);
        write_reg(sacfp_pkg::REG_PREFETCH, 1);
        write_reg(sacfp_pkg::REG_OFFSET, 3);
        write_reg(sacfp_pkg::REG_INDEX, 5);
        random_phase(350);
        drain();

        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
